>>> hdl/wsa_pkg.sv
// Shared types and codes of the window slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package wsa_pkg;

  localparam logic OP_ATTACH = 1'b0;
  localparam logic OP_DETACH = 1'b1;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_DUPLICATE  = 3'd1,
    STS_TABLE_FULL = 3'd2,
    STS_NO_SLOT    = 3'd3,
    STS_START_FAIL = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_SCAN,
    FS_DRAIN,
    FS_EVAL,
    FS_DONE
  } fsm_t;

  typedef struct packed {
    logic        op;
    logic [31:0] req_id;
    logic        start_failed;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  entry_index;
    logic [3:0]  slot_index;
    logic [4:0]  active_count;
    logic [4:0]  detached_count;
  } out_word_t;

endpackage

`default_nettype wire

>>> hdl/wsa_id_mem.sv
// Capture id memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module wsa_id_mem #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/wsa_ctrl.sv
// Request sequencer: scans the id memory, valid bits and slot mask, then commits.
`timescale 1ns / 1ps
`default_nettype none

module wsa_ctrl import wsa_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int SLOTS = 16,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           mem_we,
  output logic [AW-1:0]  mem_waddr,
  output logic [31:0]    mem_wdata,
  output logic           mem_re,
  output logic [AW-1:0]  mem_raddr,
  input  wire logic [31:0] mem_rdata,
  output logic           res_push,
  input  wire logic      res_ready,
  output out_word_t      res_word
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCAN = (ENTRIES > SLOTS) ? ENTRIES : SLOTS;
  localparam int IW = (SCAN > 1) ? $clog2(SCAN) : 1;
  localparam int CNW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(SCAN - 1);
  localparam logic [IW:0] ENT_L = (IW + 1)'(ENTRIES);
  localparam logic [IW:0] SLOT_L = (IW + 1)'(SLOTS);

  fsm_t              state_r, state_nxt;
  logic [31:0]       id_r, id_nxt;
  logic              sf_r, sf_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0]  mask_r, mask_nxt;
  logic [CNW-1:0]    total_r, total_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              pv_r, pv_nxt;
  logic [IW-1:0]     pidx_r, pidx_nxt;
  logic              dup_r, dup_nxt;
  logic              efound_r, efound_nxt;
  logic [AW-1:0]     eidx_r, eidx_nxt;
  logic              sfound_r, sfound_nxt;
  logic [SW-1:0]     sidx_r, sidx_nxt;
  out_word_t         res_r, res_nxt;

  logic p_in_ent;
  logic p_in_slot;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FS_IDLE;
      valid_r  <= '0;
      mask_r   <= '0;
      total_r  <= '0;
      pv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      mask_r   <= mask_nxt;
      total_r  <= total_nxt;
      pv_r     <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    sf_r     <= sf_nxt;
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    dup_r    <= dup_nxt;
    efound_r <= efound_nxt;
    eidx_r   <= eidx_nxt;
    sfound_r <= sfound_nxt;
    sidx_r   <= sidx_nxt;
    res_r    <= res_nxt;
  end

  assign in_stall  = (state_r != FS_IDLE);
  assign accept    = in_valid && !in_stall;
  assign p_in_ent  = ({1'b0, pidx_r} < ENT_L);
  assign p_in_slot = ({1'b0, pidx_r} < SLOT_L);
  assign res_word  = res_r;

  always_comb begin
    state_nxt  = state_r;
    id_nxt     = id_r;
    sf_nxt     = sf_r;
    valid_nxt  = valid_r;
    mask_nxt   = mask_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    pv_nxt     = 1'b0;
    pidx_nxt   = pidx_r;
    dup_nxt    = dup_r;
    efound_nxt = efound_r;
    eidx_nxt   = eidx_r;
    sfound_nxt = sfound_r;
    sidx_nxt   = sidx_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = eidx_r;
    mem_wdata  = id_r;
    mem_re     = 1'b0;
    mem_raddr  = idx_r[AW-1:0];
    res_push   = 1'b0;

    // Second half of the scan: the id read in the previous cycle is now available.
    if (pv_r) begin
      if (p_in_ent) begin
        if (valid_r[pidx_r[AW-1:0]] && (mem_rdata == id_r)) begin
          dup_nxt = 1'b1;
        end
        if (!valid_r[pidx_r[AW-1:0]] && !efound_r) begin
          efound_nxt = 1'b1;
          eidx_nxt   = pidx_r[AW-1:0];
        end
      end
      if (p_in_slot && !mask_r[pidx_r[SW-1:0]] && !sfound_r) begin
        sfound_nxt = 1'b1;
        sidx_nxt   = pidx_r[SW-1:0];
      end
    end

    unique case (state_r)
      FS_IDLE: begin
        if (accept) begin
          id_nxt = in_word.req_id;
          sf_nxt = in_word.start_failed;
          if (in_word.op == OP_DETACH) begin
            valid_nxt = '0;
            mask_nxt  = '0;
            total_nxt = '0;
            res_nxt.status         = STS_OK;
            res_nxt.entry_index    = '0;
            res_nxt.slot_index     = '0;
            res_nxt.active_count   = '0;
            res_nxt.detached_count = 5'(total_r);
            state_nxt = FS_DONE;
          end else begin
            idx_nxt    = '0;
            dup_nxt    = 1'b0;
            efound_nxt = 1'b0;
            sfound_nxt = 1'b0;
            state_nxt  = FS_SCAN;
          end
        end
      end
      FS_SCAN: begin
        mem_re   = ({1'b0, idx_r} < ENT_L);
        pv_nxt   = 1'b1;
        pidx_nxt = idx_r;
        idx_nxt  = idx_r + IW'(1);
        if (idx_r == LAST) begin
          state_nxt = FS_DRAIN;
        end
      end
      FS_DRAIN: begin
        state_nxt = FS_EVAL;
      end
      FS_EVAL: begin
        res_nxt.entry_index    = '0;
        res_nxt.slot_index     = '0;
        res_nxt.active_count   = 5'(total_r);
        res_nxt.detached_count = '0;
        priority if (dup_r) begin
          res_nxt.status = STS_DUPLICATE;
        end else if (!efound_r) begin
          res_nxt.status = STS_TABLE_FULL;
        end else if (!sfound_r) begin
          res_nxt.status = STS_NO_SLOT;
        end else if (sf_r) begin
          res_nxt.status = STS_START_FAIL;
        end else begin
          res_nxt.status       = STS_OK;
          res_nxt.entry_index  = 4'(eidx_r);
          res_nxt.slot_index   = 4'(sidx_r);
          res_nxt.active_count = 5'(total_r + CNW'(1));
          valid_nxt[eidx_r]    = 1'b1;
          mask_nxt[sidx_r]     = 1'b1;
          total_nxt            = total_r + CNW'(1);
          mem_we               = 1'b1;
        end
        state_nxt = FS_DONE;
      end
      FS_DONE: begin
        res_push = 1'b1;
        if (res_ready) begin
          state_nxt = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/window_slot_allocator_core.sv
// Top level of the window slot allocator: sequencer, id memory and output register.
`timescale 1ns / 1ps
`default_nettype none

// One request word is taken at a time. An attach walks the capture id memory
// and the slot mask one index per cycle, max(ENTRIES, SLOTS) indexes in all,
// and then evaluates and commits; once the output register has taken its
// result word, the next word can be taken in the cycle after. A detach-all
// needs no scan. The output register holds a finished word while the next
// request is already being worked on. Ids of entries never attached are not
// cleared after reset, since an id is only compared while its entry is valid.
module window_slot_allocator_core import wsa_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int SLOTS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_word
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;
  logic          res_push;
  logic          res_ready;
  out_word_t     res_word;
  logic          out_valid_r;
  out_word_t     out_word_r;

  wsa_ctrl #(
    .ENTRIES (ENTRIES),
    .SLOTS   (SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_push  (res_push),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  wsa_id_mem #(
    .DEPTH (ENTRIES)
  ) u_id_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push && res_ready) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request word taken while another is in progress");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !res_ready) |=> (res_push && $stable(res_word)))
    else $error("finished result changed before the output register took it");

  a_fail_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status != STS_OK)) |->
      ((out_word.entry_index == 4'd0) && (out_word.slot_index == 4'd0)))
    else $error("failed attach reports an entry or slot");

  a_detach_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.detached_count != 5'd0)) |->
      ((out_word.status == STS_OK) && (out_word.active_count == 5'd0)))
    else $error("detach-all word leaves entries active");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench of the window slot allocator core.
`timescale 1ns / 1ps

module testbench;
  import wsa_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_COUNT = 16;
  localparam int RANDOM_WORDS = 1430;
  localparam int HOLD_AT_REPLY = 250;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_AT_WORD = 700;

  // Tracks the allocator state and the reply words still owed by the block.
  class attach_outcome_book;
    logic        entry_busy[TABLE_DEPTH];
    logic [31:0] entry_owner[TABLE_DEPTH];
    logic [SLOT_COUNT-1:0] slots_taken;
    int unsigned attached_total;
    out_word_t   pending_replies[$];
    int          mismatches;

    function new();
      mismatches = 0;
      drop_all();
    endfunction

    function void drop_all();
      foreach (entry_busy[e]) begin
        entry_busy[e] = 1'b0;
        entry_owner[e] = '0;
      end
      slots_taken = '0;
      attached_total = 0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function void take_request(in_word_t w);
      out_word_t r;
      int dup_e;
      int free_e;
      int free_s;
      int cleared;
      r = '0;
      r.status = STS_OK;
      if (w.op == OP_DETACH) begin
        cleared = 0;
        foreach (entry_busy[e]) if (entry_busy[e]) cleared++;
        drop_all();
        r.detached_count = cleared[4:0];
      end else begin
        dup_e = -1;
        free_e = -1;
        free_s = -1;
        for (int e = 0; e < TABLE_DEPTH; e++) begin
          if (entry_busy[e] && entry_owner[e] == w.req_id && dup_e < 0) dup_e = e;
          if (!entry_busy[e] && free_e < 0) free_e = e;
        end
        for (int s = 0; s < SLOT_COUNT; s++)
          if (!slots_taken[s] && free_s < 0) free_s = s;
        // The checks are ordered: a duplicate wins over a full table, and a
        // missing slot wins over a failed start.
        if (dup_e >= 0) begin
          r.status = STS_DUPLICATE;
        end else if (free_e < 0) begin
          r.status = STS_TABLE_FULL;
        end else if (free_s < 0) begin
          r.status = STS_NO_SLOT;
        end else if (w.start_failed) begin
          r.status = STS_START_FAIL;
        end else begin
          entry_busy[free_e] = 1'b1;
          entry_owner[free_e] = w.req_id;
          slots_taken[free_s] = 1'b1;
          attached_total++;
          r.entry_index = free_e[3:0];
          r.slot_index = free_s[3:0];
        end
      end
      r.active_count = attached_total[4:0];
      pending_replies.push_back(r);
    endfunction

    function void check_reply(out_word_t got);
      out_word_t want;
      if (pending_replies.size() == 0) begin
        $error("reply word with no request pending: status %0d active_count %0d",
               got.status, got.active_count);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.entry_index !== want.entry_index) begin
        $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
        mismatches++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
        mismatches++;
      end
      if (got.active_count !== want.active_count) begin
        $error("active_count: expected %0d, got %0d", want.active_count, got.active_count);
        mismatches++;
      end
      if (got.detached_count !== want.detached_count) begin
        $error("detached_count: expected %0d, got %0d",
               want.detached_count, got.detached_count);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  attach_outcome_book book = new();
  logic [31:0] recent_ids[$];
  int words_sent;
  int replies_seen;

  window_slot_allocator_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic in_word_t make_word(logic op, logic [31:0] id, logic start_failed);
    in_word_t w;
    w.op = op;
    w.req_id = id;
    w.start_failed = start_failed;
    return w;
  endfunction

  // Long stretches without idling alternate with stretches of random gaps.
  function automatic int next_in_gap(int n);
    return ((n / 97) % 3 == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input in_word_t w, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.take_request(w);
    if (w.op == OP_ATTACH) begin
      recent_ids.push_back(w.req_id);
      if (recent_ids.size() > 24) void'(recent_ids.pop_front());
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
  endtask

  // Reply side: draws a stall per word, with one long hold-off that lets the
  // block fill up and push back on its input.
  initial begin
    int hold;
    out_stall = 1'b0;
    replies_seen = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (replies_seen == HOLD_AT_REPLY) hold = HOLD_CYCLES;
      else if ((replies_seen / 83) % 3 == 1) hold = 0;
      else hold = $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      book.check_reply(out_word);
      replies_seen++;
    end
  end

  initial begin
    in_word_t w;
    int run_len;
    int pick;
    logic [31:0] id;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    words_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty detach, id extremes, duplicate ahead of a failed
    // start, a full table, and the check order on a full table.
    send_word(make_word(OP_DETACH, 32'h0, 1'b0), 0);
    send_word(make_word(OP_ATTACH, 32'h0000_0000, 1'b0), 0);
    send_word(make_word(OP_ATTACH, 32'hFFFF_FFFF, 1'b0), 2);
    send_word(make_word(OP_ATTACH, 32'hFFFF_FFFF, 1'b1), 0);
    send_word(make_word(OP_ATTACH, 32'h1234_5678, 1'b1), 1);
    for (int i = 0; i < TABLE_DEPTH - 2; i++)
      send_word(make_word(OP_ATTACH, 32'hA5A5_0000 + i, 1'b0), $urandom_range(0, 3));
    send_word(make_word(OP_ATTACH, 32'h5A5A_5A5A, 1'b0), 0);
    send_word(make_word(OP_ATTACH, 32'h0000_0000, 1'b1), 0);
    send_word(make_word(OP_ATTACH, 32'h7FFF_FFFF, 1'b1), 0);
    send_word(make_word(OP_DETACH, 32'hFFFF_FFFF, 1'b1), 0);
    send_word(make_word(OP_ATTACH, 32'hFFFF_FFFF, 1'b0), 0);
    pause_until_drained();

    // Random part: runs of attaches with random ids, many of them repeats,
    // each run closed by a detach-all; a few stray detaches break runs early.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      run_len = $urandom_range(0, 24);
      for (int k = 0; k <= run_len && words_sent < RANDOM_WORDS; k++) begin
        pick = $urandom_range(0, 99);
        if (k == run_len || pick < 4) begin
          w = make_word(OP_DETACH, $urandom, 1'($urandom_range(0, 1)));
        end else begin
          if (pick < 40 && recent_ids.size() > 0)
            id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
          else if (pick < 45)
            id = $urandom_range(0, 3);
          else
            id = $urandom;
          w = make_word(OP_ATTACH, id, $urandom_range(0, 7) == 0);
        end
        send_word(w, next_in_gap(words_sent));
        if (words_sent == DRAIN_AT_WORD) pause_until_drained();
      end
    end
    in_valid <= 1'b0;

    while (book.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
